// ----- rtl/ffoa_pkg.sv -----
// ffoa_pkg: shared types and constants for the first-fit owner allocator.
// Used by first_fit_owner_allocator_core; no dependencies.
`default_nettype none

package ffoa_pkg;

  localparam int MEM_UNITS_DEF = 1024;
  localparam int ID_BITS_DEF   = 10;

  localparam int SIZE_W  = 11;
  localparam int OWNER_W = 10;
  localparam int ADDR_W  = 10;
  localparam int FREED_W = 11;
  localparam int CFG_W   = 11;

  localparam logic [CFG_W-1:0] MEM_UNITS_RESET = 11'd1024;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  typedef struct packed {
    logic              op;
    logic [SIZE_W-1:0]  request_size;
    logic [OWNER_W-1:0] owner_id;
  } in_item_t;

  typedef struct packed {
    logic [ADDR_W-1:0]  start_address;
    logic               alloc_failed;
    logic [FREED_W-1:0] freed_units;
  } out_item_t;

endpackage

`default_nettype wire

// ----- rtl/first_fit_owner_allocator_core.sv -----
// first_fit_owner_allocator_core: first-fit allocator over a per-unit used/owner RAM.
// Depends on ffoa_pkg and ffoa_ram.
`default_nettype none

// Each request is handled alone, through one RAM holding a used bit and an owner
// per unit, one address read per cycle under a small sequencer. After reset a
// clearing pass writes every unit free; no request is taken meanwhile (mem_units
// writes still land). An allocate scans units from address 0 until a free run
// of request_size is found or mem_units (capped at MEM_UNITS) units are seen,
// then marks the run unit by unit. A free scans all MEM_UNITS units and clears
// matching ones on the fly. A zero-size allocate fails without a scan. The
// result sits in an output register, so a new request is accepted while the
// previous result waits to be taken.
module first_fit_owner_allocator_core #(
  parameter int MEM_UNITS = ffoa_pkg::MEM_UNITS_DEF,
  parameter int ID_BITS   = ffoa_pkg::ID_BITS_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       cfg_we,
  input  wire logic [ffoa_pkg::CFG_W-1:0] cfg_wdata,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire ffoa_pkg::in_item_t         in_data,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output ffoa_pkg::out_item_t             out_data
);

  localparam int AW = (MEM_UNITS > 1) ? $clog2(MEM_UNITS) : 1;
  localparam int CW = $clog2(MEM_UNITS + 1);
  localparam int DW = ID_BITS + 1;
  localparam logic [CW-1:0] UNITS_C = CW'(MEM_UNITS);

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_ASCAN = 6'b000100,
    S_AMARK = 6'b001000,
    S_FSCAN = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  state_t state, state_next;
  logic [CW-1:0] iss_addr, iss_addr_next;
  logic rd_valid, rd_valid_next;
  logic [AW-1:0] rd_addr, rd_addr_next;
  logic [CW-1:0] run, run_next;
  logic [AW-1:0] run_start, run_start_next;
  logic [AW-1:0] mark_addr, mark_addr_next;
  logic [CW-1:0] mark_left, mark_left_next;
  logic [CW-1:0] freed, freed_next;
  logic failed, failed_next;
  logic [AW-1:0] start_r, start_r_next;
  logic [ffoa_pkg::SIZE_W-1:0] size_r, size_r_next;
  logic [ID_BITS-1:0] owner_r, owner_r_next;
  logic [ffoa_pkg::CFG_W-1:0] mem_units;
  ffoa_pkg::out_item_t out_next;
  logic out_load;

  logic we;
  logic [AW-1:0] waddr;
  logic [DW-1:0] wdata;
  logic [DW-1:0] rdata;
  logic issue;

  logic [ID_BITS+ffoa_pkg::OWNER_W-1:0] owner_ext;
  logic [ID_BITS-1:0] owner_in;
  logic [31:0] mu32, lim32, start32, freed32;
  logic [CW-1:0] limit;
  logic [CW-1:0] run_inc;
  logic rd_used;
  logic [ID_BITS-1:0] rd_owner;

  assign owner_ext = {{ID_BITS{1'b0}}, in_data.owner_id};
  assign owner_in  = owner_ext[ID_BITS-1:0];
  assign mu32      = 32'(mem_units);
  assign lim32     = (mu32 > 32'(MEM_UNITS)) ? 32'(MEM_UNITS) : mu32;
  assign limit     = lim32[CW-1:0];
  assign run_inc   = run + CW'(1);
  assign rd_used   = rdata[ID_BITS];
  assign rd_owner  = rdata[ID_BITS-1:0];
  assign start32   = 32'(start_r);
  assign freed32   = 32'(freed);
  assign in_stall  = (state != S_IDLE);

  ffoa_ram #(
    .WIDTH(DW),
    .DEPTH(MEM_UNITS)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(iss_addr[AW-1:0]),
    .rdata(rdata)
  );

  always_comb begin
    state_next     = state;
    iss_addr_next  = iss_addr;
    rd_addr_next   = rd_addr;
    run_next       = run;
    run_start_next = run_start;
    mark_addr_next = mark_addr;
    mark_left_next = mark_left;
    freed_next     = freed;
    failed_next    = failed;
    start_r_next   = start_r;
    size_r_next    = size_r;
    owner_r_next   = owner_r;
    issue          = 1'b0;
    we             = 1'b0;
    waddr          = mark_addr;
    wdata          = '0;
    out_load       = 1'b0;
    out_next.start_address = start32[ffoa_pkg::ADDR_W-1:0];
    out_next.alloc_failed  = failed;
    out_next.freed_units   = freed32[ffoa_pkg::FREED_W-1:0];

    case (state)
      S_CLEAR: begin
        we            = 1'b1;
        waddr         = iss_addr[AW-1:0];
        iss_addr_next = iss_addr + CW'(1);
        if (iss_addr == UNITS_C - CW'(1)) begin
          iss_addr_next = '0;
          state_next    = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          size_r_next   = in_data.request_size;
          owner_r_next  = owner_in;
          iss_addr_next = '0;
          run_next      = '0;
          freed_next    = '0;
          failed_next   = 1'b0;
          start_r_next  = '0;
          if (in_data.op == ffoa_pkg::OP_FREE) begin
            state_next = S_FSCAN;
          end else if (in_data.request_size == '0) begin
            failed_next = 1'b1;
            state_next  = S_DONE;
          end else begin
            state_next = S_ASCAN;
          end
        end
      end
      S_ASCAN: begin
        if (rd_valid) begin
          if (rd_used) begin
            run_next = '0;
          end else begin
            run_next = run_inc;
            if (run == '0) begin
              run_start_next = rd_addr;
            end
            if (32'(run_inc) == 32'(size_r)) begin
              start_r_next   = (run == '0) ? rd_addr : run_start;
              mark_addr_next = (run == '0) ? rd_addr : run_start;
              mark_left_next = run_inc;
              state_next     = S_AMARK;
            end
          end
        end
        if (state_next == S_ASCAN) begin
          if (iss_addr < limit) begin
            issue         = 1'b1;
            iss_addr_next = iss_addr + CW'(1);
          end else if (!rd_valid) begin
            failed_next = 1'b1;
            state_next  = S_DONE;
          end
        end
      end
      S_AMARK: begin
        we             = 1'b1;
        waddr          = mark_addr;
        wdata          = {1'b1, owner_r};
        mark_addr_next = mark_addr + AW'(1);
        mark_left_next = mark_left - CW'(1);
        if (mark_left == CW'(1)) begin
          state_next = S_DONE;
        end
      end
      S_FSCAN: begin
        if (rd_valid && rd_used && (rd_owner == owner_r)) begin
          we         = 1'b1;
          waddr      = rd_addr;
          wdata      = {1'b0, rd_owner};
          freed_next = freed + CW'(1);
        end
        if (iss_addr < UNITS_C) begin
          issue         = 1'b1;
          iss_addr_next = iss_addr + CW'(1);
        end else if (!rd_valid) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid || !out_stall) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase

    rd_valid_next = issue;
    if (issue) begin
      rd_addr_next = iss_addr[AW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      iss_addr  <= '0;
      rd_valid  <= 1'b0;
      out_valid <= 1'b0;
      mem_units <= ffoa_pkg::MEM_UNITS_RESET;
    end else begin
      state    <= state_next;
      iss_addr <= iss_addr_next;
      rd_valid <= rd_valid_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (cfg_we) begin
        mem_units <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_addr   <= rd_addr_next;
    run       <= run_next;
    run_start <= run_start_next;
    mark_addr <= mark_addr_next;
    mark_left <= mark_left_next;
    freed     <= freed_next;
    failed    <= failed_next;
    start_r   <= start_r_next;
    size_r    <= size_r_next;
    owner_r   <= owner_r_next;
    if (out_load) begin
      out_data <= out_next;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/ffoa_ram.sv -----
// ffoa_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module ffoa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire
